>>> hdl/multiset_intersection_counter_defines.svh
// ----------------------------------------------------------------------------
// multiset intersection counter assertion macros
// shared concurrent assertion forms used by the rtl modules
// ----------------------------------------------------------------------------
`ifndef MULTISET_INTERSECTION_COUNTER_DEFINES_SVH
`define MULTISET_INTERSECTION_COUNTER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MSIC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define MSIC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/msic_pkg.sv
// ----------------------------------------------------------------------------
// msic_pkg
// shared constants, codes and structs of the multiset intersection counter
// ----------------------------------------------------------------------------
package msic_pkg;

    localparam int ENTRIES    = 256;
    localparam int COUNT_BITS = 16;
    localparam int KEY_W      = 32;
    localparam int IDX_W      = $clog2(ENTRIES);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    // item mode codes
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_PROBE = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // scan status handed from cell to cell
    typedef struct packed {
        logic             active;
        logic             found;
        logic             free_seen;
        logic [IDX_W-1:0] free_idx;
    } scan_t;

    // command broadcast to every cell
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             load;
        logic             probe;
        logic             clear;
        logic             alloc_en;
        logic [IDX_W-1:0] alloc_idx;
    } cmd_t;

endpackage

>>> hdl/msic_cell.sv
// ----------------------------------------------------------------------------
// msic_cell
// one table entry: key, count and valid, plus one stage of the scan chain
// ----------------------------------------------------------------------------
`include "multiset_intersection_counter_defines.svh"

module msic_cell import msic_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [IDX_W-1:0] cell_idx,
    input  cmd_t             cmd,
    input  scan_t            scan_in,
    output scan_t            scan_out
);

    logic                  valid_reg, valid_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    scan_t                 scan_reg, scan_next;
    logic                  match;
    logic                  sel_alloc;

    assign match     = valid_reg && (key_reg == cmd.key);
    assign sel_alloc = cmd.alloc_en && (cmd.alloc_idx == cell_idx);

    always_comb begin
        valid_next = valid_reg;
        key_next   = key_reg;
        count_next = count_reg;
        priority if (cmd.clear) begin
            valid_next = 1'b0;
        end else if (sel_alloc) begin
            valid_next = 1'b1;
            key_next   = cmd.key;
            count_next = COUNT_ONE;
        end else if (scan_in.active && match) begin
            if (cmd.load) begin
                if (count_reg != COUNT_MAX) begin
                    count_next = count_reg + COUNT_ONE;
                end
            end else if (cmd.probe && (count_reg != '0)) begin
                count_next = count_reg - COUNT_ONE;
                if (count_reg == COUNT_ONE) begin
                    valid_next = 1'b0;
                end
            end
        end else begin
            // entry holds
        end
    end

    // status for the next cell
    always_comb begin
        scan_next = scan_in;
        if (scan_in.active) begin
            if (match) begin
                scan_next.found = 1'b1;
            end
            if (!valid_reg && !scan_in.free_seen) begin
                scan_next.free_seen = 1'b1;
                scan_next.free_idx  = cell_idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            scan_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            scan_reg  <= scan_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        count_reg <= count_next;
    end

    assign scan_out = scan_reg;

    `MSIC_ASSERT_IMP(a_count_nonzero, aclk, aresetn, valid_reg, count_reg != '0, "valid entry with zero count")
    `MSIC_ASSERT_NXT(a_clear_empties, aclk, aresetn, cmd.clear, !valid_reg, "entry survived a clear")
    `MSIC_ASSERT_NXT(a_valid_quiet, aclk, aresetn, !scan_in.active && !cmd.clear && !cmd.alloc_en, $stable(valid_reg), "valid changed without a command")

endmodule

>>> hdl/multiset_intersection_counter.sv
// ----------------------------------------------------------------------------
// multiset_intersection_counter
// keyed count table over a chain of entry cells, one result word per item
// ----------------------------------------------------------------------------
// usage
//   input channel s_valid/s_ready carries s_mode and s_value. a load word
//   counts its value, a probe word matches and consumes one count, a clear
//   word empties the table. mode 3 is ignored.
//   result channel m_valid/m_ready returns exactly one word per input word:
//   m_hit, m_match_value (zero without a hit) and m_table_full.
// timing
//   a load or probe word walks the cell chain, one cell per cycle, so the
//   chain length sets the time from accept to m_valid. s_ready is high only
//   in ST_IDLE: a new word waits until the last one has left ST_DONE.
//   clear and ignored words skip the walk and go straight to ST_DONE.
// reset
//   aresetn (synchronous, active low) empties the table at once, drops any
//   word in flight and clears m_valid.
// stalls
//   the result sits in an output register; the next word is taken while it
//   waits, and the engine only holds when a second result is ready behind it.
// ----------------------------------------------------------------------------
`include "multiset_intersection_counter_defines.svh"

module multiset_intersection_counter import msic_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_mode,
    input  logic signed [KEY_W-1:0] s_value,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_hit,
    output logic signed [KEY_W-1:0] m_match_value,
    output logic                    m_table_full
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic             load_reg, load_next;
    logic             probe_reg, probe_next;
    logic             start_reg, start_next;
    logic             clear_reg, clear_next;
    logic             alloc_en_reg, alloc_en_next;
    logic [IDX_W-1:0] alloc_idx_reg, alloc_idx_next;
    logic             res_hit_reg, res_hit_next;
    logic             res_full_reg, res_full_next;
    logic             m_valid_reg, m_valid_next;
    logic             m_hit_reg, m_hit_next;
    logic [KEY_W-1:0] m_match_value_reg, m_match_value_next;
    logic             m_table_full_reg, m_table_full_next;

    cmd_t             cmd;
    scan_t            scan_head;
    scan_t            scan_chain [ENTRIES];
    scan_t            scan_last;

    // broadcast command, held steady for the whole walk
    assign cmd.key       = key_reg;
    assign cmd.load      = load_reg;
    assign cmd.probe     = probe_reg;
    assign cmd.clear     = clear_reg;
    assign cmd.alloc_en  = alloc_en_reg;
    assign cmd.alloc_idx = alloc_idx_reg;

    // walk token enters cell zero with nothing seen yet
    always_comb begin
        scan_head        = '0;
        scan_head.active = start_reg;
    end

    // cell row: each passes its scan status to the next every cycle
    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        if (i == 0) begin : g_first
            msic_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .cell_idx (IDX_W'(i)),
                .cmd      (cmd),
                .scan_in  (scan_head),
                .scan_out (scan_chain[i])
            );
        end else begin : g_rest
            msic_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .cell_idx (IDX_W'(i)),
                .cmd      (cmd),
                .scan_in  (scan_chain[i-1]),
                .scan_out (scan_chain[i])
            );
        end
    end

    assign scan_last = scan_chain[ENTRIES-1];

    always_comb begin
        state_next         = state_reg;
        key_next           = key_reg;
        load_next          = load_reg;
        probe_next         = probe_reg;
        start_next         = 1'b0;
        clear_next         = 1'b0;
        alloc_en_next      = 1'b0;
        alloc_idx_next     = alloc_idx_reg;
        res_hit_next       = res_hit_reg;
        res_full_next      = res_full_reg;
        m_valid_next       = m_valid_reg;
        m_hit_next         = m_hit_reg;
        m_match_value_next = m_match_value_reg;
        m_table_full_next  = m_table_full_reg;

        // output word taken by the receiver
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    key_next      = $unsigned(s_value);
                    load_next     = (s_mode == MODE_LOAD);
                    probe_next    = (s_mode == MODE_PROBE);
                    res_hit_next  = 1'b0;
                    res_full_next = 1'b0;
                    if ((s_mode == MODE_LOAD) || (s_mode == MODE_PROBE)) begin
                        start_next = 1'b1;
                        state_next = ST_SCAN;
                    end else begin
                        // clear is registered and then empties every cell, mode 3 does nothing
                        clear_next = (s_mode == MODE_CLEAR);
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                // token left the last cell: whole table has been seen
                if (scan_last.active) begin
                    res_hit_next   = probe_reg && scan_last.found;
                    res_full_next  = load_reg && !scan_last.found && !scan_last.free_seen;
                    alloc_en_next  = load_reg && !scan_last.found && scan_last.free_seen;
                    alloc_idx_next = scan_last.free_idx;
                    state_next     = ST_DONE;
                end
            end
            ST_DONE: begin
                // wait here only while an older result is still unread
                if (!m_valid_reg || m_ready) begin
                    m_valid_next       = 1'b1;
                    m_hit_next         = res_hit_reg;
                    m_match_value_next = res_hit_reg ? key_reg : '0;
                    m_table_full_next  = res_full_reg;
                    state_next         = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            start_reg    <= 1'b0;
            clear_reg    <= 1'b0;
            alloc_en_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            start_reg    <= start_next;
            clear_reg    <= clear_next;
            alloc_en_reg <= alloc_en_next;
            m_valid_reg  <= m_valid_next;
        end
        key_reg           <= key_next;
        load_reg          <= load_next;
        probe_reg         <= probe_next;
        alloc_idx_reg     <= alloc_idx_next;
        res_hit_reg       <= res_hit_next;
        res_full_reg      <= res_full_next;
        m_hit_reg         <= m_hit_next;
        m_match_value_reg <= m_match_value_next;
        m_table_full_reg  <= m_table_full_next;
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_hit         = m_hit_reg;
    assign m_match_value = $signed(m_match_value_reg);
    assign m_table_full  = m_table_full_reg;

    `MSIC_ASSERT_IMP(a_token_in_scan, aclk, aresetn, scan_last.active, state_reg == ST_SCAN, "walk token outside scan")
    `MSIC_ASSERT_IMP(a_alloc_in_done, aclk, aresetn, alloc_en_reg, state_reg == ST_DONE, "allocation outside done")
    `MSIC_ASSERT_IMP(a_hit_not_full, aclk, aresetn, state_reg == ST_DONE, !(res_hit_reg && res_full_reg), "hit and table full together")

endmodule
